FILE: hw/rtl/pn3d_pkg.sv
package pn3d_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HASH,
    ST_FADE,
    ST_LERP,
    ST_SCALE,
    ST_OUT
  } state_t;

  localparam int unsigned ONE_Q16 = 65536;

  // Gradient dot product for the 12-direction set.
  function automatic logic signed [18:0] grad16(input logic [3:0] h,
                                                input logic signed [17:0] x,
                                                input logic signed [17:0] y,
                                                input logic signed [17:0] z);
    logic signed [18:0] u;
    logic signed [18:0] v;
    u = (h < 4'd8) ? 19'(x) : 19'(y);
    if (h < 4'd4) begin
      v = 19'(y);
    end else if (h == 4'd12 || h == 4'd14) begin
      v = 19'(x);
    end else begin
      v = 19'(z);
    end
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

endpackage

FILE: hw/rtl/pn3d_mul.sv
// Registered signed multiplier, 37 x 20 bits, one result per cycle.
module pn3d_mul (
  input  logic                clk,
  input  logic signed [36:0]  a,
  input  logic signed [19:0]  b,
  output logic signed [56:0]  p_r
);

  always_ff @(posedge clk) begin
    p_r <= 57'(a) * 57'(b);
  end

endmodule

FILE: hw/rtl/perlin_noise_3d_core.sv
// A load request writes the hash table and gives no result.
// An evaluate request raises out_tvalid after fourteen dependent reads of the single-port
// hash table, twelve fade multiplies and seven interpolation multiplies on one registered
// multiplier, and then output scaling.
// The block takes no new request until the result has been taken; it is busy meanwhile.
// Reset: rst_n is synchronous, active low; it clears control state, not the table.
module perlin_noise_3d_core #(
  parameter int COORD_FRAC_BITS = 16,
  parameter int OUT_FRAC_BITS   = 14
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // tdata: table_index[7:0], table_value[15:8], coord_x[47:16],
  // coord_y[79:48], coord_z[111:80]
  input  logic [111:0] in_tdata,
  // tuser: op[0]
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // tdata: noise_value[15:0]
  output logic [15:0]  out_tdata
);

  // Request fields.
  logic               op;
  logic [7:0]         table_index;
  logic [7:0]         table_value;
  logic [31:0]        coord [3];
  assign op          = in_tuser;
  assign table_index = in_tdata[7:0];
  assign table_value = in_tdata[15:8];
  assign coord[0]    = in_tdata[47:16];
  assign coord[1]    = in_tdata[79:48];
  assign coord[2]    = in_tdata[111:80];

  // The hash table is a single-port memory with a registered read.
  logic [7:0] mem [256];
  logic [7:0] rd_addr;
  logic [7:0] rd_data_r;
  logic       wr_en;

  pn3d_pkg::state_t state_r, state_nxt;
  logic [4:0] step_r, step_nxt;

  // Cell corner and fraction registers.
  logic [7:0]          cell_r [3];
  logic signed [17:0]  f0_r [3];
  logic [15:0]         fade_r [3];
  // Hash intermediates: A, B, AA, AB, BA, BB (9 bits before wrap).
  logic [8:0]          hv_r [6];
  logic [3:0]          hg_r [8];
  logic signed [36:0]  acc_r;
  logic signed [31:0]  lv_r [8];
  logic signed [31:0]  res_r;
  logic [15:0]         out_r;

  // Shared multiplier.
  logic signed [36:0] mul_a;
  logic signed [19:0] mul_b;
  logic signed [56:0] mul_p;

  pn3d_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  logic take;
  assign in_tready  = (state_r == pn3d_pkg::ST_IDLE);
  assign take       = in_tvalid && in_tready;
  assign wr_en      = take && !op;
  assign out_tvalid = (state_r == pn3d_pkg::ST_OUT);
  assign out_tdata  = out_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[table_index] <= table_value;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Hash sequence: read issued at even step, data usable at next step.
  // Order: X, X+1, A, A+1, B, B+1, AA, BA, AB, BB, AA+1, BA+1, AB+1, BB+1.
  always_comb begin
    case (step_r[4:1])
      4'd0:    rd_addr = cell_r[0];
      4'd1:    rd_addr = cell_r[0] + 8'd1;
      4'd2:    rd_addr = hv_r[0][7:0];
      4'd3:    rd_addr = hv_r[0][7:0] + 8'd1;
      4'd4:    rd_addr = hv_r[1][7:0];
      4'd5:    rd_addr = hv_r[1][7:0] + 8'd1;
      4'd6:    rd_addr = hv_r[2][7:0];
      4'd7:    rd_addr = hv_r[4][7:0];
      4'd8:    rd_addr = hv_r[3][7:0];
      4'd9:    rd_addr = hv_r[5][7:0];
      4'd10:   rd_addr = hv_r[2][7:0] + 8'd1;
      4'd11:   rd_addr = hv_r[4][7:0] + 8'd1;
      4'd12:   rd_addr = hv_r[3][7:0] + 8'd1;
      4'd13:   rd_addr = hv_r[5][7:0] + 8'd1;
      default: rd_addr = cell_r[0];
    endcase
  end

  // Fade per axis uses 4 multiplies, each registered; step[4:1] = axis*4+k,
  // with multiplies launched on even steps and collected on odd ones.
  logic [1:0]  fax;
  logic [1:0]  fk;
  logic [15:0] tt;
  always_comb begin
    fax = step_r[4:3];
    fk  = step_r[2:1];
    if (fax > 2'd2) fax = 2'd2;
    tt  = f0_r[fax][15:0];
  end

  // Fade polynomial g = 6t^2 - 15t*2^16 + 10*2^32, built from t^2 held in acc_r.
  // It stays between 2^32 and 10*2^32, so 37 bits hold it.
  logic [37:0] g_wide;
  logic [36:0] g_poly;
  always_comb begin
    g_wide = (38'(acc_r) * 38'd6) + (38'd10 << 32) - ((38'(tt) * 38'd15) << 16);
    g_poly = 37'(g_wide);
  end

  // Lerp schedule: steps 0..6, each a launch step and a collect step; pairs (a,b) and weight.
  logic [2:0]         li;
  logic signed [31:0] la, lb;
  logic [15:0]        lw;
  always_comb begin
    li = step_r[3:1];
    la = lv_r[0];
    lb = lv_r[1];
    lw = fade_r[0];
    case (li)
      3'd0: begin la = lv_r[0]; lb = lv_r[1]; lw = fade_r[0]; end
      3'd1: begin la = lv_r[2]; lb = lv_r[3]; lw = fade_r[0]; end
      3'd2: begin la = lv_r[4]; lb = lv_r[5]; lw = fade_r[0]; end
      3'd3: begin la = lv_r[6]; lb = lv_r[7]; lw = fade_r[0]; end
      3'd4: begin la = lv_r[0]; lb = lv_r[2]; lw = fade_r[1]; end
      3'd5: begin la = lv_r[4]; lb = lv_r[6]; lw = fade_r[1]; end
      3'd6: begin la = lv_r[0]; lb = lv_r[4]; lw = fade_r[2]; end
      default: begin la = lv_r[0]; lb = lv_r[1]; lw = fade_r[0]; end
    endcase
  end

  // Multiplier operand select. The fade runs t*t, g*t, then two more *t.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == pn3d_pkg::ST_FADE) begin
      case (fk)
        2'd0:    mul_a = 37'(tt);
        2'd1:    mul_a = g_poly;
        default: mul_a = acc_r;
      endcase
      mul_b = 20'(tt);
    end else if (state_r == pn3d_pkg::ST_LERP) begin
      mul_a = 37'(lb) - 37'(la);
      mul_b = 20'({4'd0, lw});
    end
  end

  // Next state and step counter.
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      pn3d_pkg::ST_IDLE: begin
        if (take && op) begin
          state_nxt = pn3d_pkg::ST_HASH;
          step_nxt  = '0;
        end
      end
      pn3d_pkg::ST_HASH: begin
        step_nxt = step_r + 5'd1;
        if (step_r == 5'd27) begin
          state_nxt = pn3d_pkg::ST_FADE;
          step_nxt  = '0;
        end
      end
      pn3d_pkg::ST_FADE: begin
        step_nxt = step_r + 5'd1;
        if (step_r == 5'd23) begin
          state_nxt = pn3d_pkg::ST_LERP;
          step_nxt  = '0;
        end
      end
      pn3d_pkg::ST_LERP: begin
        step_nxt = step_r + 5'd1;
        if (step_r == 5'd13) begin
          state_nxt = pn3d_pkg::ST_SCALE;
          step_nxt  = '0;
        end
      end
      pn3d_pkg::ST_SCALE: begin
        state_nxt = pn3d_pkg::ST_OUT;
      end
      pn3d_pkg::ST_OUT: begin
        if (out_tready) begin
          state_nxt = pn3d_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pn3d_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pn3d_pkg::ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // Output scaling from Q16 to OUT_FRAC_BITS with saturation.
  localparam int DN = (OUT_FRAC_BITS < 16) ? 16 - OUT_FRAC_BITS : 0;
  localparam int UP = (OUT_FRAC_BITS > 16) ? OUT_FRAC_BITS - 16 : 0;
  logic signed [39:0] scaled;
  always_comb begin
    scaled = (40'(res_r) >>> DN) <<< UP;
  end

  // Gradient values for the eight corners; corner c = {dz, dy, dx}.
  logic signed [18:0] gval [8];
  always_comb begin
    for (int c = 0; c < 8; c++) begin
      gval[c] = pn3d_pkg::grad16(hg_r[c],
                  c[0] ? f0_r[0] - 18'sd65536 : f0_r[0],
                  c[1] ? f0_r[1] - 18'sd65536 : f0_r[1],
                  c[2] ? f0_r[2] - 18'sd65536 : f0_r[2]);
    end
  end

  // Datapath registers.
  logic [15:0] frac16 [3];
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (COORD_FRAC_BITS >= 16) begin
        frac16[a] = 16'(coord[a] >> (COORD_FRAC_BITS - 16));
      end else begin
        frac16[a] = 16'(coord[a] << (16 - COORD_FRAC_BITS));
      end
    end
  end

  logic [8:0] rdz;
  assign rdz = 9'(rd_data_r) + 9'(cell_r[2]);

  always_ff @(posedge clk) begin
    if (take && op) begin
      for (int a = 0; a < 3; a++) begin
        cell_r[a] <= 8'(coord[a] >> COORD_FRAC_BITS);
        f0_r[a]   <= 18'(frac16[a]);
      end
    end
    if (state_r == pn3d_pkg::ST_HASH && step_r[0]) begin
      case (step_r[4:1])
        4'd0: hv_r[0] <= 9'(rd_data_r) + 9'(cell_r[1]);
        4'd1: hv_r[1] <= 9'(rd_data_r) + 9'(cell_r[1]);
        4'd2: hv_r[2] <= rdz;
        4'd3: hv_r[3] <= rdz;
        4'd4: hv_r[4] <= rdz;
        4'd5: hv_r[5] <= rdz;
        4'd6: hg_r[0] <= rd_data_r[3:0];
        4'd7: hg_r[1] <= rd_data_r[3:0];
        4'd8: hg_r[2] <= rd_data_r[3:0];
        4'd9: hg_r[3] <= rd_data_r[3:0];
        4'd10: hg_r[4] <= rd_data_r[3:0];
        4'd11: hg_r[5] <= rd_data_r[3:0];
        4'd12: hg_r[6] <= rd_data_r[3:0];
        4'd13: hg_r[7] <= rd_data_r[3:0];
        default: ;
      endcase
    end
    // Fade: k=0 collects t^2, k=1 collects g*t >> 32, k=2 collects >> 16,
    // and k=3 collects the last >> 16 as the fade of that axis.
    if (state_r == pn3d_pkg::ST_FADE && step_r[0]) begin
      case (fk)
        2'd0:    acc_r <= 37'(mul_p);
        2'd1:    acc_r <= 37'(mul_p >>> 32);
        2'd2:    acc_r <= 37'(mul_p >>> 16);
        default: fade_r[fax] <= 16'(mul_p >>> 16);
      endcase
    end
    if (state_r == pn3d_pkg::ST_FADE && step_r == 5'd23) begin
      // Corner order for lerp: l00 pair (0,1), l10 (2,3), l01 (4,5), l11 (6,7).
      lv_r[0] <= 32'(gval[0]);
      lv_r[1] <= 32'(gval[1]);
      lv_r[2] <= 32'(gval[2]);
      lv_r[3] <= 32'(gval[3]);
      lv_r[4] <= 32'(gval[4]);
      lv_r[5] <= 32'(gval[5]);
      lv_r[6] <= 32'(gval[6]);
      lv_r[7] <= 32'(gval[7]);
    end
    if (state_r == pn3d_pkg::ST_LERP && step_r[0]) begin
      case (li)
        3'd0: lv_r[0] <= la + 32'(mul_p >>> 16);
        3'd1: lv_r[2] <= la + 32'(mul_p >>> 16);
        3'd2: lv_r[4] <= la + 32'(mul_p >>> 16);
        3'd3: lv_r[6] <= la + 32'(mul_p >>> 16);
        3'd4: lv_r[0] <= la + 32'(mul_p >>> 16);
        3'd5: lv_r[4] <= la + 32'(mul_p >>> 16);
        default: res_r <= la + 32'(mul_p >>> 16);
      endcase
    end
    if (state_r == pn3d_pkg::ST_SCALE) begin
      if (scaled > 40'sd32767) begin
        out_r <= 16'h7fff;
      end else if (scaled < -40'sd32768) begin
        out_r <= 16'h8000;
      end else begin
        out_r <= 16'(scaled);
      end
    end
  end

  // The block never takes a request while a result is pending.
  assert property (@(posedge clk) disable iff (!rst_n) out_tvalid |-> !in_tready)
    else $error("request accepted while result pending");
  // An evaluate request always starts the hash phase.
  assert property (@(posedge clk) disable iff (!rst_n)
    (take && op) |=> (state_r == pn3d_pkg::ST_HASH))
    else $error("evaluate did not start");
  // A load request produces no result.
  assert property (@(posedge clk) disable iff (!rst_n)
    (take && !op) |=> !out_tvalid)
    else $error("load produced a result");

endmodule
